// ===== design/b64d_pkg.sv =====
// Package for the base64url strict decoder.
// Holds the transfer payload types, error codes and the character table.
// No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  // Error codes reported on the last character of a string
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BADCHAR  = 3'd1,
    ERR_PAD      = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_LEFTOVER = 3'd4
  } err_code_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Input transfer payload
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       end_of_string;
    logic [2:0] error_code;
  } out_item_t;

  // Decoded character: ok flag and six-bit value
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Map one base64url character to its six-bit value
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    logic [7:0] t;
    s = '0;
    t = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
      s = {1'b1, t[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h61 + 8'd26;
      s = {1'b1, t[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30 + 8'd52;
      s = {1'b1, t[5:0]};
    end else if (c == 8'h2D) begin
      s = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      s = {1'b1, 6'd63};
    end
    return s;
  endfunction

endpackage

// ===== design/b64d_in_stage.sv =====
// Input register stage of the base64url decoder.
// Depends on b64d_pkg for the input payload type.
`timescale 1ns / 1ps

module b64d_in_stage
  import b64d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     take,        // downstream consumes the held item this cycle
  output logic     held_valid,
  output in_item_t held_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;
  logic     load;

  // Accept a new transfer when empty or when the held item moves on
  assign load     = !valid_r || take;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = in_valid;
      item_nxt  = in_item;
    end
  end

  // Hold control under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

// ===== design/b64d_core.sv =====
// Decode step of the base64url decoder: character table, bit accumulator,
// sticky error and final checks. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_core
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,       // item is processed and its result registered
  input  in_item_t  item,
  output out_item_t result
);

  logic [5:0] buf_r, buf_nxt;
  logic [2:0] held_r, held_nxt;
  err_code_t  sticky_r, sticky_nxt;

  sextet_t    sx;
  logic [5:0] v;
  logic [11:0] acc;
  logic [3:0] nb_sum;
  logic       have;
  logic [2:0] nb;
  logic [11:0] shifted;
  logic [11:0] mask;
  logic [11:0] kept;
  logic [5:0] buf_new;
  err_code_t  err_mid;
  err_code_t  err_fin;

  always_comb begin
    // Classify the character and update the error seen so far
    sx = sextet_of(item.char_code);
    if (item.char_code == PAD_CHAR) begin
      err_mid = ERR_PAD;
    end else if (!sx.ok && sticky_r == ERR_NONE) begin
      err_mid = ERR_BADCHAR;
    end else begin
      err_mid = sticky_r;
    end
    v = sx.ok ? sx.val : 6'd0;

    // Append six bits and take out a byte when eight are ready
    acc     = {buf_r, v};
    nb_sum  = {1'b0, held_r} + 4'd6;
    have    = nb_sum >= 4'd8;
    nb      = have ? 3'(nb_sum - 4'd8) : nb_sum[2:0];
    shifted = acc >> nb;
    mask    = (12'd1 << nb) - 12'd1;
    kept    = acc & mask;
    buf_new = kept[5:0];

    // Suppress bytes once an error is seen
    result.byte_valid    = have && (err_mid == ERR_NONE);
    result.data_byte     = result.byte_valid ? shifted[7:0] : 8'd0;
    result.end_of_string = item.is_last;

    // Final checks, in priority order
    if (err_mid == ERR_PAD) begin
      err_fin = ERR_PAD;
    end else if (nb == 3'd6) begin
      err_fin = ERR_LENGTH;
    end else if (err_mid != ERR_NONE) begin
      err_fin = err_mid;
    end else if (nb != 3'd0 && buf_new != 6'd0) begin
      err_fin = ERR_LEFTOVER;
    end else begin
      err_fin = ERR_NONE;
    end
    result.error_code = item.is_last ? err_fin : ERR_NONE;

    // Next state: clear at end of string
    buf_nxt    = buf_r;
    held_nxt   = held_r;
    sticky_nxt = sticky_r;
    if (adv) begin
      if (item.is_last) begin
        buf_nxt    = 6'd0;
        held_nxt   = 3'd0;
        sticky_nxt = ERR_NONE;
      end else begin
        buf_nxt    = buf_new;
        held_nxt   = nb;
        sticky_nxt = err_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r    <= 6'd0;
      held_r   <= 3'd0;
      sticky_r <= ERR_NONE;
    end else begin
      buf_r    <= buf_nxt;
      held_r   <= held_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

// ===== design/base64url_strict_decoder.sv =====
// Base64url strict decoder, one character per transfer, one result each.
// Path: the input register holds each character, then the result register
// holds its result, which transfers while out_stall is low.
// Throughput: one character per cycle unless stalled; single decode step.
// Reset (rst_n low, synchronous) empties both registers and clears the
// accumulator and sticky error. Depends on b64d_pkg, b64d_in_stage, b64d_core.
`timescale 1ns / 1ps

module base64url_strict_decoder
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      held_valid;
  in_item_t  held_item;
  logic      out_free;
  logic      adv;
  out_item_t result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Advance when the result register is empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = held_valid && out_free;

  b64d_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (adv),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  b64d_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (held_item),
    .result (result)
  );

  // Load the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_free) begin
      out_valid_nxt = held_valid;
      out_item_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
